[rtl/str_pkg.sv]
// shared types and constants for the stream tag replacer
// used by str_front, str_op_queue, str_back and stream_tag_replacer; no dependencies
package str_pkg;

   localparam int CHAR_W          = 8;
   localparam int WORD_CHARS      = 8;                  // characters in one packed register
   localparam int WORD_W          = CHAR_W * WORD_CHARS;
   localparam int LEN_W           = 4;                  // length registers and word counts
   localparam int IDX_W           = $clog2(WORD_CHARS);
   localparam int CSR_IDX_W       = 2;
   localparam int TAG_MAX         = 8;
   localparam int REPLACEMENT_MAX = 8;
   localparam int REPL_EFF        = (REPLACEMENT_MAX < WORD_CHARS) ? REPLACEMENT_MAX : WORD_CHARS;
   localparam int OPQ_DEPTH       = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAG_CHARS   = 2'd0,
      CSR_TAG_LENGTH  = 2'd1,
      CSR_REPL_CHARS  = 2'd2,
      CSR_REPL_LENGTH = 2'd3
   } str_csr_index_type;

   // one emit job: count words taken from data, lowest byte first
   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic [LEN_W-1:0]  count;
      logic              last;
   } str_op_type;

endpackage

[rtl/str_front.sv]
// front end: configuration registers, pending window and match classification
// depends on str_pkg; produces at most one emit job per accepted character
module str_front #(
   parameter int TAG_MAX = str_pkg::TAG_MAX
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [str_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [str_pkg::WORD_W-1:0]       csr_data,
   input  logic                             in_accept,
   input  logic [str_pkg::CHAR_W-1:0]       in_char,
   input  logic                             in_last,
   output logic                             op_push,
   output str_pkg::str_op_type              op
);
   import str_pkg::*;

   localparam int TAG_EFF    = (TAG_MAX < WORD_CHARS) ? TAG_MAX : WORD_CHARS;
   localparam int WIN        = TAG_EFF;
   localparam int PEND_DEPTH = (TAG_EFF > 1) ? TAG_EFF - 1 : 1;
   localparam int PCNT_W     = $clog2(PEND_DEPTH + 1);
   localparam int WIN_W      = WIN * CHAR_W;
   localparam logic [LEN_W-1:0] TAG_EFF_LEN  = LEN_W'(TAG_EFF);
   localparam logic [LEN_W-1:0] REPL_EFF_LEN = LEN_W'(REPL_EFF);

   logic [WORD_W-1:0] tag_chars_ff;
   logic [LEN_W-1:0]  tag_length_ff;
   logic [WORD_W-1:0] repl_chars_ff;
   logic [LEN_W-1:0]  repl_length_ff;
   logic [CHAR_W-1:0] pend_ff [PEND_DEPTH];
   logic [CHAR_W-1:0] pend_in [PEND_DEPTH];
   logic [PCNT_W-1:0] pcount_ff;
   logic [PCNT_W-1:0] pcount_in;

   logic [LEN_W-1:0]  tag_len;
   logic [LEN_W-1:0]  repl_len;
   logic [LEN_W-1:0]  n_chars;
   logic [LEN_W-1:0]  keep_start;
   logic [WIN_W-1:0]  win_vec;
   logic [WIN_W-1:0]  shifted;
   logic              full_match;
   logic [WIN:0]      prefix_ok;
   logic              tag_write;

   // effective lengths
   always_comb begin
      if (tag_length_ff == '0) begin
         tag_len = LEN_W'(1);
      end else if (tag_length_ff > TAG_EFF_LEN) begin
         tag_len = TAG_EFF_LEN;
      end else begin
         tag_len = tag_length_ff;
      end
      repl_len = (repl_length_ff > REPL_EFF_LEN) ? REPL_EFF_LEN : repl_length_ff;
   end

   assign n_chars = LEN_W'(pcount_ff) + LEN_W'(1);

   // window: pending characters then the new one
   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         if (LEN_W'(i) == LEN_W'(pcount_ff)) begin
            win_vec[i*CHAR_W +: CHAR_W] = in_char;
         end else if (i < PEND_DEPTH && LEN_W'(i) < LEN_W'(pcount_ff)) begin
            win_vec[i*CHAR_W +: CHAR_W] = pend_ff[(i < PEND_DEPTH) ? i : 0];
         end else begin
            win_vec[i*CHAR_W +: CHAR_W] = '0;
         end
      end
   end

   // whole tag at the window start, and suffixes that are still a tag prefix
   always_comb begin
      full_match = (n_chars == tag_len);
      for (int j = 0; j < WIN; j++) begin
         if (LEN_W'(j) < tag_len &&
             win_vec[j*CHAR_W +: CHAR_W] != tag_chars_ff[j*CHAR_W +: CHAR_W]) begin
            full_match = 1'b0;
         end
      end
      for (int k = 0; k <= WIN; k++) begin
         prefix_ok[k] = 1'b1;
         for (int j = 0; j < WIN; j++) begin
            if (k + j < WIN) begin
               if (LEN_W'(k + j) < n_chars &&
                   win_vec[((k + j < WIN) ? k + j : 0)*CHAR_W +: CHAR_W] !=
                   tag_chars_ff[j*CHAR_W +: CHAR_W]) begin
                  prefix_ok[k] = 1'b0;
               end
            end
         end
      end
      // a run as long as the tag is a full match or a mismatch, never pending
      if (n_chars >= tag_len) begin
         prefix_ok[0] = 1'b0;
      end
   end

   // first position that can still start a match
   always_comb begin
      keep_start = LEN_W'(WIN);
      for (int k = WIN; k >= 0; k--) begin
         if (prefix_ok[k]) begin
            keep_start = LEN_W'(k);
         end
      end
   end

   assign shifted = win_vec >> (CHAR_W * keep_start);

   always_comb begin
      op.last   = in_last;
      pcount_in = '0;
      if (full_match) begin
         op.data  = repl_chars_ff;
         op.count = repl_len;
      end else if (in_last) begin
         op.data  = WORD_W'(win_vec);
         op.count = n_chars;
      end else begin
         op.data   = WORD_W'(win_vec);
         op.count  = keep_start;
         pcount_in = PCNT_W'(n_chars - keep_start);
      end
      for (int i = 0; i < PEND_DEPTH; i++) begin
         pend_in[i] = shifted[i*CHAR_W +: CHAR_W];
      end
   end

   // nothing to send when the job has no words (whole window pending, or empty replacement), unless text ends
   assign op_push = in_accept && (op.count != '0 || in_last);

   // a tag write empties the window
   assign tag_write = csr_write_en &&
                      (str_csr_index_type'(csr_index) inside {CSR_TAG_CHARS, CSR_TAG_LENGTH});

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_chars_ff   <= '0;
         tag_length_ff  <= LEN_W'(1);
         repl_chars_ff  <= '0;
         repl_length_ff <= '0;
         pcount_ff      <= '0;
      end else begin
         if (tag_write) begin
            pcount_ff <= '0;
         end else if (in_accept) begin
            pcount_ff <= pcount_in;
         end
         if (csr_write_en) begin
            unique case (str_csr_index_type'(csr_index))
               CSR_TAG_CHARS: begin
                  tag_chars_ff <= csr_data;
               end
               CSR_TAG_LENGTH: begin
                  tag_length_ff <= csr_data[LEN_W-1:0];
               end
               CSR_REPL_CHARS: begin
                  repl_chars_ff <= csr_data;
               end
               CSR_REPL_LENGTH: begin
                  repl_length_ff <= csr_data[LEN_W-1:0];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

[rtl/str_op_queue.sv]
// short queue of emit jobs between front and back ends
// depends on str_pkg for the job type
module str_op_queue #(
   parameter int DEPTH = str_pkg::OPQ_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  str_pkg::str_op_type push_op,
   output logic                full,
   output logic                head_valid,
   output str_pkg::str_op_type head_op,
   input  logic                head_pop
);
   import str_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   str_op_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign do_pop     = head_pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[rtl/str_back.sv]
// back end: expands emit jobs into result words, one per cycle unless rsp stalls, into the output register
// depends on str_pkg for the job type
module str_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  str_pkg::str_op_type         head_op,
   output logic                        head_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic [str_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic                        rsp_empty_out,
   output logic                        rsp_last_out
);
   import str_pkg::*;

   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic              out_valid_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic [CHAR_W-1:0] out_char_in;
   logic              out_empty_ff;
   logic              out_last_ff;
   logic              marker;
   logic              final_word;
   logic              load;

   assign marker     = (head_op.count == '0);
   assign final_word = marker || (LEN_W'(idx_ff) == head_op.count - LEN_W'(1));
   assign load       = head_valid && (!out_valid_ff || pop);
   assign head_pop   = load && final_word;
   assign idx_in     = final_word ? '0 : idx_ff + IDX_W'(1);
   assign out_char_in = marker ? '0 : head_op.data[idx_ff*CHAR_W +: CHAR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= idx_in;
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_char_ff  <= out_char_in;
         out_empty_ff <= marker;
         out_last_ff  <= head_op.last && final_word;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_char_out  = out_char_ff;
   assign rsp_empty_out = out_empty_ff;
   assign rsp_last_out  = out_last_ff;

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_empty_ff |-> out_last_ff)
      else $error("end marker without last");

   a_empty_job_ends_text: assert property (@(posedge clock) disable iff (reset)
      head_valid && marker |-> head_op.last)
      else $error("empty job that does not end a text");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (LEN_W'(idx_ff) < head_op.count) || (idx_ff == '0))
      else $error("word index beyond job length");

   a_idx_restarts: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (idx_ff == '0))
      else $error("word index not cleared after job");

endmodule

[rtl/stream_tag_replacer.sv]
// top level of the stream tag replacer: front end, job queue and back end
// depends on str_pkg, str_front, str_op_queue and str_back
//
//   channel  direction  handshake          words
//   req      in         push / full        req_char_in, req_last_in
//   rsp      out        empty / pop        rsp_char_out, rsp_empty_out, rsp_last_out
//   csr      in         csr_write_en       csr_index, csr_data (no wait, no read-back)
//
// one character is accepted per cycle while the job queue has room
// a character that causes m result words (m up to 8, an end marker is one word) holds the back end until
// all m have gone out through the single result-word port of the back end
// a result word passes through the job queue and then the output register before it shows on the rsp ports
// reset is synchronous and clears the window count, the job queue and the output register, and resets the csr registers
// a stall on rsp fills the job queue and then raises full; push does not affect rsp
module stream_tag_replacer #(
   parameter int TAG_MAX = str_pkg::TAG_MAX
) (
   input  logic                            clock,
   input  logic                            reset,
   // character input
   input  logic                            push,
   output logic                            full,
   input  logic [str_pkg::CHAR_W-1:0]      req_char_in,
   input  logic                            req_last_in,
   // rewritten text output
   output logic                            empty,
   input  logic                            pop,
   output logic [str_pkg::CHAR_W-1:0]      rsp_char_out,
   output logic                            rsp_empty_out,
   output logic                            rsp_last_out,
   // configuration writes
   input  logic                            csr_write_en,
   input  logic [str_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [str_pkg::WORD_W-1:0]      csr_data
);
   import str_pkg::*;

   logic       in_accept;
   logic       op_push;
   str_op_type op;
   logic       head_valid;
   str_op_type head_op;
   logic       head_pop;

   // a character is taken whenever the queue can hold the job it may create
   assign in_accept = push && !full;

   // classify the character against the window, build its emit job
   str_front #(
      .TAG_MAX (TAG_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .in_accept    (in_accept),
      .in_char      (req_char_in),
      .in_last      (req_last_in),
      .op_push      (op_push),
      .op           (op)
   );

   // decouples the front from output stalls
   str_op_queue #(
      .DEPTH (OPQ_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (op_push),
      .push_op    (op),
      .full       (full),
      .head_valid (head_valid),
      .head_op    (head_op),
      .head_pop   (head_pop)
   );

   // one result word per cycle into the output register, unless rsp stalls
   str_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_op       (head_op),
      .head_pop      (head_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_char_out  (rsp_char_out),
      .rsp_empty_out (rsp_empty_out),
      .rsp_last_out  (rsp_last_out)
   );

endmodule
